### rtl/letter_statistics_histogram_unit_macros.svh
// assertion helpers for the histogram unit
`ifndef LETTER_STATISTICS_HISTOGRAM_UNIT_MACROS_SVH
`define LETTER_STATISTICS_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LSH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsh check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define LSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsh check failed: next-cycle rule");

`endif

### rtl/lsh_pkg.sv
package lsh_pkg;

  localparam int NUM_LETTERS    = 26;
  localparam int IDX_W          = 5;
  localparam int CHAR_W         = 8;
  localparam int OUT_CNT_W      = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int DATA_W         = 48;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'd44;
  localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'd46;

  typedef struct packed {
    logic take;     // text byte accepted this cycle
    logic advance;  // result beat taken downstream
    logic clear;    // final result beat taken
  } lsh_cmd_t;

  typedef struct packed {
    logic final_beat;
  } lsh_sts_t;

  typedef struct packed {
    logic                 run_last;
    logic                 list_valid;
    logic [IDX_W-1:0]     list_letter;
    logic [OUT_CNT_W-1:0] top_count;
    logic [IDX_W-1:0]     top_letter;
    logic [IDX_W-1:0]     distinct_total;
    logic [OUT_CNT_W-1:0] letter_total;
    logic                 legal;
  } lsh_res_t;

endpackage

### rtl/lsh_ctrl.sv
module lsh_ctrl
  import lsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tlast,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  lsh_sts_t sts,
  output lsh_cmd_t cmd
);

  localparam logic ST_TAKE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    s_tready    = (state == ST_TAKE);
    m_tvalid    = (state == ST_EMIT);
    cmd.take    = s_tvalid && s_tready;
    cmd.advance = m_tvalid && m_tready;
    cmd.clear   = cmd.advance && sts.final_beat;
    state_next  = state;
    unique case (state)
      ST_TAKE: begin
        if (cmd.take && s_tlast) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.clear) state_next = ST_TAKE;
      end
      default: state_next = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/lsh_dp.sv
module lsh_dp
  import lsh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lsh_cmd_t          cmd,
  input  logic [CHAR_W-1:0] char_code,
  output lsh_sts_t          sts,
  output lsh_res_t          res
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] counts [NUM_LETTERS];
  logic [IDX_W-1:0]      first_rank [NUM_LETTERS];
  logic [IDX_W-1:0]      appearance_order [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] seen;
  logic [IDX_W-1:0]      distinct;
  logic [COUNT_BITS-1:0] letters_seen;
  logic                  legal;
  logic [IDX_W-1:0]      best_letter;
  logic [IDX_W-1:0]      best_rank;
  logic [COUNT_BITS-1:0] best_count;
  logic [IDX_W-1:0]      emit_k;

  logic                  is_lower;
  logic                  is_upper;
  logic                  is_letter;
  logic                  is_punct;
  logic [IDX_W-1:0]      letter_idx;
  logic                  is_new;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [IDX_W-1:0]      rank_cur;
  logic                  take_best;
  logic                  take_letter;
  logic [COUNT_BITS+OUT_CNT_W-1:0] total_ext;
  logic [COUNT_BITS+OUT_CNT_W-1:0] best_ext;

  always_comb begin
    is_lower  = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z);
    is_upper  = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
    is_letter = is_lower || is_upper;
    is_punct  = (char_code == CH_SPACE) || (char_code == CH_COMMA) ||
                (char_code == CH_PERIOD);
    if (is_lower) letter_idx = IDX_W'(char_code - CH_LOWER_A);
    else if (is_upper) letter_idx = IDX_W'(char_code - CH_UPPER_A);
    else letter_idx = '0;
    take_letter = cmd.take && is_letter;
    is_new   = !seen[letter_idx];
    cnt_cur  = is_new ? '0 : counts[letter_idx];
    cnt_new  = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    rank_cur = is_new ? distinct : first_rank[letter_idx];
    // tie goes to the letter that showed up first
    take_best = (cnt_new > best_count) ||
                ((cnt_new == best_count) && (letter_idx != best_letter) &&
                 (rank_cur < best_rank));
  end

  always_ff @(posedge clk) begin
    if (take_letter) begin
      counts[letter_idx] <= cnt_new;
      if (is_new) begin
        first_rank[letter_idx]     <= distinct;
        appearance_order[distinct] <= letter_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      seen         <= '0;
      distinct     <= '0;
      letters_seen <= '0;
      legal        <= 1'b1;
      best_letter  <= '0;
      best_rank    <= '0;
      best_count   <= '0;
      emit_k       <= '0;
    end else begin
      if (take_letter) begin
        seen[letter_idx] <= 1'b1;
        if (is_new) distinct <= distinct + IDX_W'(1);
        if (letters_seen != CNT_MAX) letters_seen <= letters_seen + COUNT_BITS'(1);
        if (take_best) begin
          best_letter <= letter_idx;
          best_rank   <= rank_cur;
          best_count  <= cnt_new;
        end
      end
      if (cmd.take && !is_letter && !is_punct) legal <= 1'b0;
      if (cmd.advance) emit_k <= emit_k + IDX_W'(1);
    end
  end

  always_comb begin
    total_ext = {{OUT_CNT_W{1'b0}}, letters_seen};
    best_ext  = {{OUT_CNT_W{1'b0}}, best_count};
    sts.final_beat     = (distinct == '0) || (emit_k == IDX_W'(distinct - IDX_W'(1)));
    res.legal          = legal;
    res.letter_total   = total_ext[OUT_CNT_W-1:0];
    res.distinct_total = distinct;
    res.top_letter     = best_letter;
    res.top_count      = best_ext[OUT_CNT_W-1:0];
    res.list_valid     = (distinct != '0);
    res.list_letter    = (distinct == '0) ? '0 : appearance_order[emit_k];
    res.run_last       = sts.final_beat;
  end

endmodule

### rtl/letter_statistics_histogram_unit.sv
// channel | dir | tdata (low bit up)                                   | tuser      | tlast
// s       | in  | char_code[7:0]                                       | -          | end_of_text
// m       | out | legal, letter_total, distinct_total, top_letter,     | list_valid | run_last
//         |     | top_count, list_letter (48 bits)                     |            |
// text bytes are taken one per cycle outside the result run; each letter updates its count,
// total and leader in that cycle through a single read-modify-write of the letter count registers
// after the final byte, input stalls while 1 to 26 result beats go out, one per cycle of m_tready
// the last result beat clears all statistics in that cycle; the next text starts right after
// synchronous reset clears the same state and leaves the unit ready for text
`include "letter_statistics_histogram_unit_macros.svh"

module letter_statistics_histogram_unit
  import lsh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // char_code[7:0]
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // legal, letter_total, distinct_total, top_letter,
                                       // top_count, list_letter
  output logic              m_tuser,   // list_valid
  output logic              m_tlast
);

  lsh_cmd_t cmd;
  lsh_sts_t sts;
  lsh_res_t res;

  lsh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsh_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_code (s_tdata),
    .sts       (sts),
    .res       (res)
  );

  assign m_tdata = {res.list_letter, res.top_count, res.top_letter,
                    res.distinct_total, res.letter_total, res.legal};
  assign m_tuser = res.list_valid;
  assign m_tlast = res.run_last;

  `LSH_ASSERT_NOW(a_no_overlap, clk, rst, s_tready, !m_tvalid)
  `LSH_ASSERT_NEXT(a_final_starts_run, clk, rst, s_tvalid && s_tready && s_tlast, m_tvalid)
  `LSH_ASSERT_NEXT(a_run_end_frees, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)
  `LSH_ASSERT_NOW(a_empty_single, clk, rst, m_tvalid && !m_tuser, m_tlast)

endmodule

### test/tb_letter_statistics_histogram_unit.sv
module tb_letter_statistics_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lsh_pkg::*;

  localparam int unsigned CNT_LIMIT   = (1 << COUNT_BITS_DEF) - 1;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_BYTES = 80;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  letter_statistics_histogram_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // running text statistics, mirrored from the accepted byte stream
  int unsigned      tally[NUM_LETTERS];
  logic [IDX_W-1:0] rank_of[NUM_LETTERS];
  logic [IDX_W-1:0] seen_order[NUM_LETTERS];
  int unsigned      distinct_cnt;
  int unsigned      letter_cnt;
  logic             text_legal;
  logic [IDX_W-1:0] leader;
  int unsigned      leader_cnt;

  lsh_res_t pending_stats[$];

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int beats_checked = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  function automatic void clear_tally();
    for (int i = 0; i < NUM_LETTERS; i++) begin
      tally[i] = 0;
      rank_of[i] = '0;
      seen_order[i] = '0;
    end
    distinct_cnt = 0;
    letter_cnt = 0;
    text_legal = 1'b1;
    leader = '0;
    leader_cnt = 0;
  endfunction

  function automatic void count_letter(int idx);
    int unsigned c;
    if (tally[idx] == 0 && distinct_cnt < NUM_LETTERS) begin
      seen_order[distinct_cnt] = IDX_W'(idx);
      rank_of[idx] = IDX_W'(distinct_cnt);
      distinct_cnt++;
    end
    if (tally[idx] < CNT_LIMIT) tally[idx]++;
    if (letter_cnt < CNT_LIMIT) letter_cnt++;
    c = tally[idx];
    if (c > leader_cnt) begin
      leader_cnt = c;
      leader = IDX_W'(idx);
    end else if (c == leader_cnt && idx != leader && rank_of[idx] < rank_of[leader]) begin
      // tie goes to the letter that showed up first
      leader = IDX_W'(idx);
    end
  endfunction

  function automatic void tally_byte(logic [CHAR_W-1:0] ch, logic last);
    int n;
    lsh_res_t row;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) count_letter(int'(ch - CH_LOWER_A));
    else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) count_letter(int'(ch - CH_UPPER_A));
    else if (!(ch == CH_SPACE || ch == CH_COMMA || ch == CH_PERIOD)) text_legal = 1'b0;
    if (!last) return;
    n = (distinct_cnt == 0) ? 1 : int'(distinct_cnt);
    for (int k = 0; k < n; k++) begin
      row.legal          = text_legal;
      row.letter_total   = OUT_CNT_W'(letter_cnt);
      row.distinct_total = IDX_W'(distinct_cnt);
      row.top_letter     = leader;
      row.top_count      = OUT_CNT_W'(leader_cnt);
      row.list_letter    = (distinct_cnt == 0) ? '0 : seen_order[k];
      row.list_valid     = (distinct_cnt != 0);
      row.run_last       = (k == n - 1);
      pending_stats.push_back(row);
    end
    clear_tally();
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_stats(lsh_res_t got);
    lsh_res_t want;
    if (pending_stats.size() == 0) begin
      $display("[%0t] unexpected statistics beat 0x%0h", $realtime, got);
      errors++;
      return;
    end
    want = pending_stats.pop_front();
    beats_checked++;
    if (got.legal != want.legal) report_mismatch("legal", got.legal, want.legal);
    if (got.letter_total != want.letter_total)
      report_mismatch("letter_total", got.letter_total, want.letter_total);
    if (got.distinct_total != want.distinct_total)
      report_mismatch("distinct_total", got.distinct_total, want.distinct_total);
    if (got.top_letter != want.top_letter)
      report_mismatch("top_letter", got.top_letter, want.top_letter);
    if (got.top_count != want.top_count)
      report_mismatch("top_count", got.top_count, want.top_count);
    if (got.list_letter != want.list_letter)
      report_mismatch("list_letter", got.list_letter, want.list_letter);
    if (got.list_valid != want.list_valid)
      report_mismatch("list_valid", got.list_valid, want.list_valid);
    if (got.run_last != want.run_last)
      report_mismatch("run_last", got.run_last, want.run_last);
  endtask

  // input side feeds the mirror first, so a beat is never checked ahead of its text
  always @(posedge clk) begin
    if (rst) begin
      clear_tally();
    end else begin
      if (s_tvalid && s_tready) tally_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_stats(lsh_res_t'({m_tlast, m_tuser, m_tdata}));
    end
  end

  // receiver stalls follow a byte pattern that is redrawn whenever the low six bits of the cycle count are zero
  logic [7:0] stall_pattern = 8'hFF;
  logic [2:0] stall_phase = '0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles[5:0] == 6'd0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    end
    stall_phase <= stall_phase + 3'd1;
    m_tready <= stall_pattern[stall_phase];
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(logic [CHAR_W-1:0] ch, logic last);
    if (burst_left == 0) begin
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
  endtask

  task automatic wait_for_stats();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_no_letters();
    send_text(".");
    send_text(" ,");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_tie_break();
    // b overtakes a, then a draws level and wins back on first appearance
    send_text("abBA,");
    send_text("q");
  endtask

  task automatic test_range_edges();
    send_text("A@Z[a`z{");
    send_byte(8'd128, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_full_alphabet();
    send_text("zYxWvUtSrQpOnMlKjIhGfEdCbA");
    wait_for_stats();
  endtask

  function automatic logic [CHAR_W-1:0] random_text_byte(int kind, int span, int base);
    int r;
    logic [CHAR_W-1:0] idx;
    r = $urandom_range(0, 9);
    idx = CHAR_W'(base + $urandom_range(0, span - 1));
    if (kind == 8) return CHAR_W'($urandom_range(0, 255));
    if (kind == 9 && r == 0) return CHAR_W'($urandom_range(128, 255));
    if (kind == 7 || r >= 7) begin
      case ($urandom_range(0, 2))
        0: return CH_SPACE;
        1: return CH_COMMA;
        default: return CH_PERIOD;
      endcase
    end
    return ($urandom_range(0, 1) != 0) ? CH_UPPER_A + idx : CH_LOWER_A + idx;
  endfunction

  task automatic test_random_texts();
    int start;
    int len;
    int kind;
    int span;
    int base;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      // narrow letter spans make repeats and ties common
      span = $urandom_range(1, NUM_LETTERS);
      base = $urandom_range(0, NUM_LETTERS - span);
      for (int i = 0; i < len; i++) send_byte(random_text_byte(kind, span, base), i == len - 1);
      if ($urandom_range(0, 5) == 0) wait_for_stats();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_letters();
    test_tie_break();
    test_range_edges();
    wait_for_stats();
    test_full_alphabet();
    test_random_texts();
    wait_for_stats();
    repeat (40) @(posedge clk);
    if (pending_stats.size() != 0) begin
      $display("%0d statistics beats never arrived", pending_stats.size());
      errors++;
    end
    $display("sent %0d text bytes in %0d texts, checked %0d statistics beats",
             bytes_sent, texts_sent, beats_checked);
    $display("included empty, illegal, tied, full-alphabet and random mixed texts");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
